>>> hw/rtl/nmfd_pkg.sv
`default_nettype none
package nmfd_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned CIDX_W     = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DECIM_W    = 11;
  localparam int unsigned CNT_W      = 10;
  localparam logic [DECIM_W-1:0] MAX_DECIM = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM     = 1'd1;

  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // one entry of the queue between front and back
  typedef struct packed {
    logic                     is_sample;
    logic                     emit;
    logic                     clip;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } q_entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/nmfd_if.sv
`default_nettype none
interface nmfd_in_if;
  import nmfd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] sample_re;
  logic signed [DATA_W-1:0] sample_im;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;
  modport source (output valid, cmd, sample_re, sample_im, coef_index, coef_value,
                  input ready);
  modport sink (input valid, cmd, sample_re, sample_im, coef_index, coef_value,
                output ready);
endinterface

interface nmfd_out_if;
  import nmfd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_re;
  logic signed [DATA_W-1:0] out_im;
  logic                     clipped;
  modport source (output valid, out_re, out_im, clipped, input ready);
  modport sink (input valid, out_re, out_im, clipped, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/nmfd_front.sv
`default_nettype none
module nmfd_front import nmfd_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  nmfd_in_if.sink                    in_i,
  input  wire logic [31:0]           phase_inc_i,
  input  wire logic [DECIM_W-1:0]    decim_i,
  output logic                       push_o,
  output q_entry_t                   push_entry_o,
  input  wire logic                  full_i
);

  localparam int unsigned IW  = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int unsigned RAW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PW  = 32 + IW;

  // quadrant boundaries of the table index
  localparam logic [IW:0] D1 = (IW+1)'(SINE_TABLE_DEPTH);
  localparam logic [IW:0] D2 = (IW+1)'(2 * SINE_TABLE_DEPTH);
  localparam logic [IW:0] D3 = (IW+1)'(3 * SINE_TABLE_DEPTH);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_ADDR = 3'd1;
  localparam logic [2:0] F_ROM  = 3'd2;
  localparam logic [2:0] F_MUL  = 3'd3;
  localparam logic [2:0] F_SUM  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  // quarter-wave sine entry, Q30 taylor series truncated at every step
  function automatic logic [14:0] sine_val(input int unsigned k);
    longint unsigned x, x2, term, val;
    longint sum;
    x    = (longint'(k) * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    val = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
    if (val > 32767) val = 32767;
    return val[14:0];
  endfunction

  // folds a table index into a quarter-wave address and a sign
  function automatic logic [RAW:0] fold(input logic [IW:0] idx);
    logic [1:0]   q;
    logic [IW:0]  r;
    logic [IW:0]  a;
    priority if (idx >= D3) begin
      q = 2'd3;
      r = idx - D3;
    end else if (idx >= D2) begin
      q = 2'd2;
      r = idx - D2;
    end else if (idx >= D1) begin
      q = 2'd1;
      r = idx - D1;
    end else begin
      q = 2'd0;
      r = idx;
    end
    a = q[0] ? (D1 - r) : r;
    return {q[1], a[RAW-1:0]};
  endfunction

  logic [14:0] rom [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = sine_val(k);
  end

  logic [2:0]               f_q;
  logic [31:0]              phase_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [IW-1:0]            idx_q;
  logic [RAW-1:0]           s_addr_q, c_addr_q;
  logic                     s_neg_q, c_neg_q;
  logic [14:0]              s_mag_q, c_mag_q;
  logic signed [DATA_W-1:0] a_q, b_q;
  logic signed [32:0]       p_ac_q, p_bs_q, p_bc_q, p_as_q;
  q_entry_t                 ent_q;

  logic              acc;
  logic [PW-1:0]     idx_prod;
  logic [DECIM_W-1:0] factor;
  logic [RAW:0]      s_fold, c_fold;
  logic [IW:0]       c_idx;
  logic signed [16:0] s_val, c_val;
  logic signed [33:0] re_sum, im_sum;
  logic signed [18:0] re_rnd, im_rnd;

  assign in_i.ready   = (f_q == F_IDLE);
  assign acc          = in_i.valid && in_i.ready;
  assign push_o       = (f_q == F_PUSH) && !full_i;
  assign push_entry_o = ent_q;

  assign idx_prod = PW'(phase_q) * PW'(4 * SINE_TABLE_DEPTH);
  assign factor   = (decim_i == '0) ? DECIM_W'(1) :
                    ((decim_i > MAX_DECIM) ? MAX_DECIM : decim_i);

  always_comb begin
    c_idx = {1'b0, idx_q} + (IW+1)'(SINE_TABLE_DEPTH);
    if (c_idx >= (IW+1)'(4 * SINE_TABLE_DEPTH)) begin
      c_idx = c_idx - (IW+1)'(4 * SINE_TABLE_DEPTH);
    end
  end
  assign s_fold = fold({1'b0, idx_q});
  assign c_fold = fold(c_idx);

  assign s_val  = s_neg_q ? -$signed({2'b00, s_mag_q}) : $signed({2'b00, s_mag_q});
  assign c_val  = c_neg_q ? -$signed({2'b00, c_mag_q}) : $signed({2'b00, c_mag_q});
  assign re_sum = 34'(p_ac_q) + 34'(p_bs_q);
  assign im_sum = 34'(p_bc_q) - 34'(p_as_q);
  assign re_rnd = 19'((re_sum + 34'sd16384) >>> 15);
  assign im_rnd = 19'((im_sum + 34'sd16384) >>> 15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q     <= F_IDLE;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (f_q)
        F_IDLE: begin
          if (acc) begin
            if (in_i.cmd == CMD_SAMPLE) begin
              phase_q <= phase_q + phase_inc_i;
              if ((DECIM_W'(cnt_q) + DECIM_W'(1)) >= factor) begin
                cnt_q <= '0;
              end else begin
                cnt_q <= cnt_q + CNT_W'(1);
              end
              f_q <= F_ADDR;
            end else begin
              f_q <= F_PUSH;
            end
          end
        end
        F_ADDR:  f_q <= F_ROM;
        F_ROM:   f_q <= F_MUL;
        F_MUL:   f_q <= F_SUM;
        F_SUM:   f_q <= F_PUSH;
        F_PUSH: begin
          if (!full_i) f_q <= F_IDLE;
        end
        default: f_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      idx_q            <= idx_prod[PW-1:32];
      a_q              <= in_i.sample_re;
      b_q              <= in_i.sample_im;
      ent_q.is_sample  <= in_i.cmd;
      ent_q.emit       <= (cnt_q == '0);
      ent_q.clip       <= 1'b0;
      ent_q.re         <= '0;
      ent_q.im         <= '0;
      ent_q.coef_index <= in_i.coef_index;
      ent_q.coef_value <= in_i.coef_value;
    end
    if (f_q == F_ADDR) begin
      s_addr_q <= s_fold[RAW-1:0];
      s_neg_q  <= s_fold[RAW];
      c_addr_q <= c_fold[RAW-1:0];
      c_neg_q  <= c_fold[RAW];
    end
    if (f_q == F_ROM) begin
      s_mag_q <= rom[s_addr_q];
      c_mag_q <= rom[c_addr_q];
    end
    if (f_q == F_MUL) begin
      p_ac_q <= a_q * c_val;
      p_bs_q <= b_q * s_val;
      p_bc_q <= b_q * c_val;
      p_as_q <= a_q * s_val;
    end
    if (f_q == F_SUM) begin
      ent_q.clip <= (re_rnd > 19'sd32767) || (re_rnd < -19'sd32768) ||
                    (im_rnd > 19'sd32767) || (im_rnd < -19'sd32768);
      ent_q.re   <= (re_rnd > 19'sd32767) ? 16'sd32767 :
                    ((re_rnd < -19'sd32768) ? -16'sd32768 : re_rnd[15:0]);
      ent_q.im   <= (im_rnd > 19'sd32767) ? 16'sd32767 :
                    ((im_rnd < -19'sd32768) ? -16'sd32768 : im_rnd[15:0]);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/nmfd_queue.sv
`default_nettype none
module nmfd_queue import nmfd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t push_entry_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output q_entry_t      pop_entry_o,
  output logic          valid_o
);

  q_entry_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o      = (cnt_q == 2'd2);
  assign valid_o     = (cnt_q != 2'd0);
  assign pop_entry_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_entry_i;
  end

endmodule
`default_nettype wire

>>> hw/rtl/nmfd_back.sv
`default_nettype none
module nmfd_back import nmfd_pkg::*; #(
  parameter int unsigned TAPS = 100
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire q_entry_t entry_i,
  input  wire logic     valid_i,
  output logic          pop_o,
  nmfd_out_if.source    out_o
);

  localparam int unsigned TW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned AW = 34 + $clog2(TAPS) + 1;
  localparam int unsigned RW = AW - 17;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_WAIT = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic signed [DATA_W-1:0] dly_re [TAPS];
  logic signed [DATA_W-1:0] dly_im [TAPS];
  logic signed [COEF_W-1:0] tap_mem [TAPS];
  logic [TAPS-1:0]          dvld_q, tvld_q;

  logic [1:0]               b_q;
  logic [TW-1:0]            ptr_q, rd_ptr_q, i_q;
  logic                     clip_q, v1_q, v2_q, dv_q, tv_q;
  logic signed [DATA_W-1:0] dre_q, dim_q;
  logic signed [COEF_W-1:0] tap_q;
  logic signed [33:0]       pre_q, pim_q;
  logic signed [AW-1:0]     acc_re_q, acc_im_q;
  logic                     ov_q, oclip_q;
  logic signed [DATA_W-1:0] ore_q, oim_q;

  logic                     coef_ok;
  logic [TW-1:0]            nptr, cidx;
  logic signed [RW-1:0]     r_re, r_im;
  logic                     r_clip, out_free;

  assign pop_o    = (b_q == B_IDLE) && valid_i;
  assign cidx     = TW'(entry_i.coef_index);
  assign coef_ok  = (32'(entry_i.coef_index) < TAPS);
  assign nptr     = (ptr_q == TW'(TAPS - 1)) ? '0 : ptr_q + TW'(1);
  assign out_free = !ov_q || out_o.ready;

  assign r_re   = RW'((acc_re_q + AW'(65536)) >>> 17);
  assign r_im   = RW'((acc_im_q + AW'(65536)) >>> 17);
  assign r_clip = (r_re > RW'(32767)) || (r_re < -RW'(32768)) ||
                  (r_im > RW'(32767)) || (r_im < -RW'(32768));

  assign out_o.valid   = ov_q;
  assign out_o.out_re  = ore_q;
  assign out_o.out_im  = oim_q;
  assign out_o.clipped = oclip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q    <= B_IDLE;
      ptr_q  <= '0;
      dvld_q <= '0;
      tvld_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      v1_q <= (b_q == B_RUN);
      v2_q <= v1_q;
      if ((b_q == B_OUT) && out_free) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
      unique case (b_q)
        B_IDLE: begin
          if (pop_o) begin
            if (entry_i.is_sample) begin
              ptr_q        <= nptr;
              dvld_q[nptr] <= 1'b1;
              if (entry_i.emit) b_q <= B_RUN;
            end else if (coef_ok) begin
              tvld_q[cidx] <= 1'b1;
            end
          end
        end
        B_RUN: begin
          if (i_q == TW'(TAPS - 1)) b_q <= B_WAIT;
        end
        B_WAIT: begin
          if (!v1_q && !v2_q) b_q <= B_OUT;
        end
        B_OUT: begin
          if (out_free) b_q <= B_IDLE;
        end
        default: b_q <= B_IDLE;
      endcase
    end
  end

  // storage and datapath
  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.is_sample) begin
      dly_re[nptr] <= entry_i.re;
      dly_im[nptr] <= entry_i.im;
    end
    if (pop_o && !entry_i.is_sample && coef_ok) begin
      tap_mem[cidx] <= entry_i.coef_value;
    end
    dre_q <= dly_re[rd_ptr_q];
    dim_q <= dly_im[rd_ptr_q];
    tap_q <= tap_mem[i_q];
    dv_q  <= dvld_q[rd_ptr_q];
    tv_q  <= tvld_q[i_q];
    pre_q <= (dv_q ? dre_q : DATA_W'(0)) * (tv_q ? tap_q : COEF_W'(0));
    pim_q <= (dv_q ? dim_q : DATA_W'(0)) * (tv_q ? tap_q : COEF_W'(0));
    if (pop_o) begin
      i_q      <= '0;
      rd_ptr_q <= nptr;
      clip_q   <= entry_i.clip;
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else begin
      if (b_q == B_RUN) begin
        i_q      <= i_q + TW'(1);
        rd_ptr_q <= (rd_ptr_q == '0) ? TW'(TAPS - 1) : rd_ptr_q - TW'(1);
      end
      if (v2_q) begin
        acc_re_q <= acc_re_q + AW'(pre_q);
        acc_im_q <= acc_im_q + AW'(pim_q);
      end
    end
    if ((b_q == B_OUT) && out_free) begin
      ore_q   <= (r_re > RW'(32767)) ? 16'sd32767 :
                 ((r_re < -RW'(32768)) ? -16'sd32768 : r_re[15:0]);
      oim_q   <= (r_im > RW'(32767)) ? 16'sd32767 :
                 ((r_im < -RW'(32768)) ? -16'sd32768 : r_im[15:0]);
      oclip_q <= clip_q || r_clip;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/nco_mixer_fir_decimator_unit.sv
// path: a sample passes the front's address, table, multiply and sum states to the queue;
//   an emitted result needs the back to run all taps through its serial multiply-accumulate
// flow: the front takes a new item only after pushing the last; the back takes no entry
//   while an emitting sample runs its taps or its result waits to be taken
// reset: asynchronous active low; clears control, phase, decimation count and the valid
//   bits of delay line and taps, which then read as zero; no clearing pass
`default_nettype none
module nco_mixer_fir_decimator_unit import nmfd_pkg::*; #(
  parameter int unsigned TAPS             = 100,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  nmfd_in_if.sink                    in_i,
  nmfd_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [31:0]        phase_inc_q;
  logic [DECIM_W-1:0] decim_q;

  // front to queue, queue to back
  logic     push, full, pop, q_valid;
  q_entry_t push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= '0;
      decim_q     <= DECIM_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_INC: phase_inc_q <= cfg_data_i;
        CFG_DECIM:     decim_q     <= cfg_data_i[DECIM_W-1:0];
        default: ;
      endcase
    end
  end

  // front: nco lookup, complex mix, rounding, decimation decision
  nmfd_front #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .phase_inc_i  (phase_inc_q),
    .decim_i      (decim_q),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  // two-entry queue keeps front and back stalling on their own
  nmfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .valid_o      (q_valid)
  );

  // back: tap writes, delay line, fir accumulation, output register
  nmfd_back #(
    .TAPS(TAPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (pop_entry),
    .valid_i (q_valid),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

>>> dv/nco_mixer_fir_decimator_unit_test.sv
`default_nettype none
module nco_mixer_fir_decimator_unit_test import nmfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NTAPS      = 100;
  localparam int unsigned QDEPTH     = 1024;
  // cycles the block may still be busy after the last result
  localparam int unsigned DRAIN_WAIT = NTAPS + 30;
  localparam int unsigned STALL_MAX  = 20000;
  localparam int unsigned RAND_ITEMS = 1700;

  // down converter predictor: nco mixer, fir, decimator, plus pending results
  class ddc_scoreboard;
    typedef struct {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic                     clip;
    } ddc_result_t;

    logic signed [DATA_W-1:0] line_re[NTAPS];
    logic signed [DATA_W-1:0] line_im[NTAPS];
    logic signed [COEF_W-1:0] coefs[NTAPS];
    int                       quarter_sine[QDEPTH+1];
    logic [CFG_DATA_W-1:0]    phase;
    logic [CFG_DATA_W-1:0]    phase_step;
    logic [DECIM_W-1:0]       decim;
    int unsigned              decim_cnt;
    ddc_result_t              pending[$];
    int                       errors;

    function new();
      longint unsigned x, x2, term, val, k, n;
      longint          sum;
      for (k = 0; k <= QDEPTH; k++) begin
        // taylor series in q30, each step truncated
        x    = (k * HALF_PI_Q30 + QDEPTH / 2) / QDEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
          if (n[0]) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        val = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (val > 32767) val = 32767;
        quarter_sine[k] = int'(val);
      end
      for (int i = 0; i < NTAPS; i++) begin
        line_re[i] = '0;
        line_im[i] = '0;
        coefs[i]   = '0;
      end
      phase      = '0;
      phase_step = '0;
      decim      = 11'd1;
      decim_cnt  = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PHASE_INC) phase_step = data;
      else decim = data[DECIM_W-1:0];
    endfunction

    function longint sine_at(int unsigned idx);
      int unsigned q, r;
      longint      v;
      idx = idx % (4 * QDEPTH);
      q   = idx / QDEPTH;
      r   = idx % QDEPTH;
      v   = q[0] ? quarter_sine[QDEPTH - r] : quarter_sine[r];
      return (q >= 2) ? -v : v;
    endfunction

    // round half up, arithmetic shift
    function longint round_sh(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function logic signed [DATA_W-1:0] sat16(longint v, inout logic clip);
      if (v > 32767) begin
        clip = 1'b1;
        return 16'sh7fff;
      end
      if (v < -32768) begin
        clip = 1'b1;
        return 16'sh8000;
      end
      return v[DATA_W-1:0];
    endfunction

    function void note_input(logic cmd, logic signed [DATA_W-1:0] s_re,
                             logic signed [DATA_W-1:0] s_im, logic [CIDX_W-1:0] cidx,
                             logic signed [COEF_W-1:0] cval);
      longint      a, b, c, s, acc_re, acc_im;
      int unsigned idx, factor;
      logic        clip, emit;
      ddc_result_t res;
      clip = 1'b0;
      if (cmd == CMD_COEF) begin
        // loads past the last tap are dropped
        if (cidx < NTAPS) coefs[cidx] = cval;
        return;
      end
      a     = s_re;
      b     = s_im;
      idx   = phase >> 20;
      s     = sine_at(idx);
      c     = sine_at(idx + QDEPTH);
      phase = phase + phase_step;
      for (int i = NTAPS - 1; i > 0; i--) begin
        line_re[i] = line_re[i-1];
        line_im[i] = line_im[i-1];
      end
      line_re[0] = sat16(round_sh(a * c + b * s, 15), clip);
      line_im[0] = sat16(round_sh(b * c - a * s, 15), clip);
      acc_re = 0;
      acc_im = 0;
      for (int i = 0; i < NTAPS; i++) begin
        acc_re += longint'(line_re[i]) * longint'(coefs[i]);
        acc_im += longint'(line_im[i]) * longint'(coefs[i]);
      end
      factor = decim;
      if (factor == 0) factor = 1;
      if (factor > MAX_DECIM) factor = MAX_DECIM;
      emit = (decim_cnt == 0);
      if (decim_cnt + 1 >= factor) decim_cnt = 0;
      else decim_cnt++;
      if (!emit) return;
      res.re   = sat16(round_sh(acc_re, 17), clip);
      res.im   = sat16(round_sh(acc_im, 17), clip);
      res.clip = clip;
      pending.insert(pending.size(), res);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] re, logic signed [DATA_W-1:0] im,
                               logic clip);
      ddc_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d clipped=%0b", $realtime, re, im, clip);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (re !== want.re) begin
        $display("%0t: out_re expected %0d actual %0d", $realtime, want.re, re);
        errors++;
      end
      if (im !== want.im) begin
        $display("%0t: out_im expected %0d actual %0d", $realtime, want.im, im);
        errors++;
      end
      if (clip !== want.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $realtime, want.clip, clip);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  nmfd_in_if  in_ch();
  nmfd_out_if out_ch();

  nco_mixer_fir_decimator_unit #(
    .TAPS             (NTAPS),
    .SINE_TABLE_DEPTH (QDEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  ddc_scoreboard sb = new();

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          hold_cycles  = 0;   // long receiver stall, counted below
  int unsigned results_seen = 0;
  int unsigned rand_sent    = 0;
  int unsigned quiet_cycles = 0;

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // receiver: check on accept, then pick ready for the next edge
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_re, out_ch.out_im, out_ch.clipped);
        results_seen++;
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // watchdog on cycles without any accepted item
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one item, optionally after random idle cycles, and wait for accept
  task automatic send_item(logic cmd, logic signed [DATA_W-1:0] s_re,
                           logic signed [DATA_W-1:0] s_im, logic [CIDX_W-1:0] cidx,
                           logic signed [COEF_W-1:0] cval);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.sample_re  <= s_re;
    in_ch.sample_im  <= s_im;
    in_ch.coef_index <= cidx;
    in_ch.coef_value <= cval;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(cmd, s_re, s_im, cidx, cval);
  endtask

  task automatic send_sample(logic signed [DATA_W-1:0] s_re, logic signed [DATA_W-1:0] s_im);
    send_item(CMD_SAMPLE, s_re, s_im, CIDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(logic [CIDX_W-1:0] cidx, logic signed [COEF_W-1:0] cval);
    send_item(CMD_COEF, DATA_W'($urandom), DATA_W'($urandom), cidx, cval);
  endtask

  // sender stops until every pending result is back, then lets the pipe empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // mostly samples, some tap loads with full or small values, some past the last tap
  task automatic send_random();
    logic [CIDX_W-1:0] cidx;
    if (rand_sent < RAND_ITEMS / 3) begin
      src_idle_pct = 19;
      snk_idle_pct = 45;
    end else if (rand_sent < 2 * RAND_ITEMS / 3) begin
      src_idle_pct = 45;
      snk_idle_pct = 19;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    rand_sent++;
    if ($urandom_range(99) < 85) begin
      send_sample(pick_sample(), pick_sample());
    end else begin
      cidx = ($urandom_range(9) == 0) ? CIDX_W'($urandom_range(127, NTAPS))
                                      : CIDX_W'($urandom_range(NTAPS - 1));
      if ($urandom_range(1)) send_coef(cidx, COEF_W'($urandom));
      else send_coef(cidx, COEF_W'($urandom_range(8191)) - 18'sd4096);
    end
  endtask

  typedef struct {
    logic [CFG_DATA_W-1:0] step;
    logic [DECIM_W-1:0]    factor;
    int                    items;     // 0: run until two results came
  } ddc_phase_t;

  initial begin
    ddc_phase_t  plan[5];
    int unsigned start;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_COEF;
    in_ch.sample_re  <= '0;
    in_ch.sample_im  <= '0;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: eighth-turn steps so full-scale samples overflow the mixer
    write_cfg(CFG_PHASE_INC, 32'h2000_0000);
    write_cfg(CFG_DECIM, 11'd1);
    send_sample(16'sh7fff, 16'sh7fff);      // taps still zero
    send_coef(7'd0, 18'sh1ffff);
    send_coef(7'd1, 18'sh1ffff);
    send_coef(7'd2, 18'sh1ffff);
    send_coef(7'd99, 18'sh20000);
    send_coef(7'd100, 18'sh1ffff);          // past the last tap, dropped
    send_coef(7'd127, 18'sh20000);          // dropped too
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh0001, -16'sh0001);
    send_coef(7'd1, 18'sh00000);
    send_coef(7'd2, -18'sh00001);
    send_sample(16'sh4000, 16'shc000);
    send_sample(16'sh7fff, 16'sh0000);
    send_sample(16'sh0000, 16'sh8000);
    drain();

    plan[0] = '{32'($urandom), 11'd1, 150};
    plan[1] = '{32'hffff_ffff, 11'd3, 150};
    plan[2] = '{32'h0000_0000, 11'd0, 150};    // zero factor acts as one
    plan[3] = '{32'($urandom), 11'd2047, 0};   // above the cap, acts as 1024
    plan[4] = '{32'($urandom), 11'd2, 100};    // lowered factor mid-stream
    foreach (plan[p]) begin
      write_cfg(CFG_PHASE_INC, plan[p].step);
      write_cfg(CFG_DECIM, plan[p].factor);
      if (plan[p].items > 0) begin
        for (int n = 0; n < plan[p].items; n++) begin
          if (p == 0 && n == 100) hold_cycles = 400;  // fill the block up
          if (p == 2 && n == 75) drain();
          send_random();
        end
      end else begin
        start = results_seen;
        while (results_seen - start < 2) send_random();
      end
      drain();
    end

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/nmfd_pkg.sv
hw/rtl/nmfd_if.sv
hw/rtl/nmfd_front.sv
hw/rtl/nmfd_queue.sv
hw/rtl/nmfd_back.sv
hw/rtl/nco_mixer_fir_decimator_unit.sv
dv/nco_mixer_fir_decimator_unit_test.sv
